>>> src/ffa_pkg.sv
// Shared types and constants for the first-fit block allocator.
// Item and result structs, status codes and the controller/datapath interface.
// No dependencies.
package ffa_pkg;

   localparam int ADDR_BITS   = 20;
   localparam int LIMIT_BITS  = 21;
   localparam int SUM_BITS    = ADDR_BITS + 2;
   localparam int STATUS_BITS = 3;

   localparam int DEFAULT_MAX_BLOCKS   = 64;
   localparam int DEFAULT_HEADER_BYTES = 24;

   localparam logic [LIMIT_BITS-1:0] ADDR_SPAN   = LIMIT_BITS'(1) << ADDR_BITS;
   localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = LIMIT_BITS'(1048576);

   localparam logic [1:0] CMD_ALLOC   = 2'd0;
   localparam logic [1:0] CMD_FREE    = 2'd1;
   localparam logic [1:0] CMD_REALLOC = 2'd2;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_OK           = 3'd0,
      ST_NO_HEAP      = 3'd1,
      ST_ZERO_SIZE    = 3'd2,
      ST_UNKNOWN_ADDR = 3'd3,
      ST_TABLE_FULL   = 3'd4
   } status_type;

   typedef struct packed {
      logic [1:0]           command;
      logic [ADDR_BITS-1:0] request_bytes;
      logic [ADDR_BITS-1:0] data_address;
   } req_item_type;

   typedef struct packed {
      logic [ADDR_BITS-1:0]   result_address;
      logic [STATUS_BITS-1:0] status;
      logic                   kept_in_place;
      logic [ADDR_BITS-1:0]   copy_bytes;
   } rsp_item_type;

   // controller -> datapath
   typedef struct packed {
      logic       accept;
      logic       scan_clear;
      logic       scan_run;
      logic       scan_fit;
      logic       cap_loc;
      logic       claim_fit;
      logic       grow;
      logic       set_copy;
      logic       set_kept;
      logic       set_status;
      status_type status_code;
      logic       rel_start;
      logic       rel_step;
      logic       rel_merge;
      logic       load_rsp;
   } ctrl_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic [1:0] command;
      logic       req_zero;
      logic       addr_zero;
      logic       scan_done;
      logic       scan_hit;
      logic       loc_fits;
      logic       grow_ok;
      logic       rel_end;
      logic       rel_linked;
      logic       rel_free;
      logic       rsp_free;
   } dp_stat_type;

endpackage

>>> src/ffa_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read data.
// No dependencies.
module ffa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/ffa_dp.sv
// Allocator datapath: block table (offset/size RAMs, free/linked flags),
// heap top, scan pointer, result and output registers.
// Depends on ffa_pkg and ffa_ram.
module ffa_dp
   import ffa_pkg::*;
#(
   parameter int MAX_BLOCKS   = DEFAULT_MAX_BLOCKS,
   parameter int HEADER_BYTES = DEFAULT_HEADER_BYTES
) (
   input  logic                  clock,
   input  logic                  reset,
   input  req_item_type          req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_item_type          rsp_data,
   input  logic                  csr_wen,
   input  logic [LIMIT_BITS-1:0] csr_wdata,
   input  ctrl_cmd_type          cmd,
   output dp_stat_type           stat
);

   localparam int IDXW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int CNTW = $clog2(MAX_BLOCKS + 1);
   localparam logic [ADDR_BITS:0] HDR_W = (ADDR_BITS + 1)'(HEADER_BYTES);
   localparam logic [CNTW-1:0] MAX_CNT = CNTW'(MAX_BLOCKS);

   // control state
   logic [LIMIT_BITS-1:0] limit_ff, limit_in;
   logic [ADDR_BITS:0]    heap_top_ff, heap_top_in;
   logic [CNTW-1:0]       count_ff, count_in;
   logic [MAX_BLOCKS-1:0] free_ff, free_in;
   logic [MAX_BLOCKS-1:0] linked_ff, linked_in;
   logic [CNTW-1:0]       ptr_ff, ptr_in;
   logic                  pend_vld_ff, pend_vld_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   // payload
   req_item_type          item_ff, item_in;
   logic [ADDR_BITS:0]    need_ff, need_in;
   logic [IDXW-1:0]       pend_idx_ff, pend_idx_in;
   logic [IDXW-1:0]       loc_idx_ff, loc_idx_in;
   logic [ADDR_BITS-1:0]  loc_size_ff, loc_size_in;
   logic [ADDR_BITS-1:0]  res_addr_ff, res_addr_in;
   status_type            res_status_ff, res_status_in;
   logic                  res_kept_ff, res_kept_in;
   logic [ADDR_BITS-1:0]  res_copy_ff, res_copy_in;
   rsp_item_type          rsp_data_ff, rsp_data_in;

   // RAM ports
   logic                  off_we, size_we;
   logic [IDXW-1:0]       size_waddr;
   logic [ADDR_BITS-1:0]  off_wdata, size_wdata;
   logic [ADDR_BITS-1:0]  off_rd, size_rd;
   logic [IDXW-1:0]       rd_addr;

   // combinational helpers
   logic [ADDR_BITS-1:0]  req_m1;
   logic [ADDR_BITS-3:0]  need_units;
   logic [IDXW-1:0]       ptr_idx, cnt_idx;
   logic [ADDR_BITS:0]    hit_data_addr, merged, top_data_addr;
   logic                  match_hit, fit_hit, scan_hit, scan_done;
   logic [SUM_BITS-1:0]   grow_sum;
   logic [LIMIT_BITS-1:0] limit_eff;
   logic                  over_limit, table_full, grow_do;

   assign ptr_idx = ptr_ff[IDXW-1:0];
   assign cnt_idx = count_ff[IDXW-1:0];
   assign rd_addr = ptr_idx;

   ffa_ram #(.WIDTH(ADDR_BITS), .DEPTH(MAX_BLOCKS)) u_off_ram (
      .clock   (clock),
      .wr_en   (off_we),
      .wr_addr (cnt_idx),
      .wr_data (off_wdata),
      .rd_addr (rd_addr),
      .rd_data (off_rd)
   );

   ffa_ram #(.WIDTH(ADDR_BITS), .DEPTH(MAX_BLOCKS)) u_size_ram (
      .clock   (clock),
      .wr_en   (size_we),
      .wr_addr (size_waddr),
      .wr_data (size_wdata),
      .rd_addr (rd_addr),
      .rd_data (size_rd)
   );

   // round up to a multiple of 8
   assign req_m1     = req_data.request_bytes - ADDR_BITS'(1);
   assign need_units = {1'b0, req_m1[ADDR_BITS-1:3]} + (ADDR_BITS - 2)'(1);

   // entry under test is the one whose RAM data just arrived
   assign hit_data_addr = {1'b0, off_rd} + HDR_W;
   assign match_hit = linked_ff[pend_idx_ff] &&
                      (hit_data_addr == {1'b0, item_ff.data_address});
   assign fit_hit   = linked_ff[pend_idx_ff] && free_ff[pend_idx_ff] &&
                      ({1'b0, size_rd} >= need_ff);
   assign scan_hit  = pend_vld_ff && (cmd.scan_fit ? fit_hit : match_hit);
   assign scan_done = scan_hit || (!pend_vld_ff && (ptr_ff >= count_ff));

   assign limit_eff  = (limit_ff > ADDR_SPAN) ? ADDR_SPAN : limit_ff;
   assign grow_sum   = {1'b0, heap_top_ff} + SUM_BITS'(HDR_W) + {1'b0, need_ff};
   assign over_limit = grow_sum > SUM_BITS'(limit_eff);
   assign table_full = count_ff >= MAX_CNT;
   assign grow_do    = cmd.grow && !over_limit && !table_full;
   assign top_data_addr = heap_top_ff + HDR_W;

   assign merged = {1'b0, loc_size_ff} + HDR_W + {1'b0, size_rd};

   assign off_we     = grow_do;
   assign off_wdata  = heap_top_ff[ADDR_BITS-1:0];
   assign size_we    = grow_do || cmd.rel_merge;
   assign size_waddr = cmd.rel_merge ? loc_idx_ff : cnt_idx;
   assign size_wdata = cmd.rel_merge ? merged[ADDR_BITS-1:0] : need_ff[ADDR_BITS-1:0];

   always_comb begin
      limit_in      = limit_ff;
      heap_top_in   = heap_top_ff;
      count_in      = count_ff;
      free_in       = free_ff;
      linked_in     = linked_ff;
      ptr_in        = ptr_ff;
      pend_vld_in   = pend_vld_ff;
      rsp_valid_in  = rsp_valid_ff;
      item_in       = item_ff;
      need_in       = need_ff;
      pend_idx_in   = pend_idx_ff;
      loc_idx_in    = loc_idx_ff;
      loc_size_in   = loc_size_ff;
      res_addr_in   = res_addr_ff;
      res_status_in = res_status_ff;
      res_kept_in   = res_kept_ff;
      res_copy_in   = res_copy_ff;
      rsp_data_in   = rsp_data_ff;

      if (csr_wen) begin
         limit_in = csr_wdata;
      end

      if (cmd.accept) begin
         item_in       = req_data;
         need_in       = {need_units, 3'b000};
         res_addr_in   = '0;
         res_status_in = ST_OK;
         res_kept_in   = 1'b0;
         res_copy_in   = '0;
      end

      if (cmd.scan_clear) begin
         ptr_in      = '0;
         pend_vld_in = 1'b0;
      end

      // one read issued per cycle, checked the cycle after
      if (cmd.scan_run) begin
         if (!scan_hit && (ptr_ff < count_ff)) begin
            ptr_in      = ptr_ff + CNTW'(1);
            pend_vld_in = 1'b1;
            pend_idx_in = ptr_idx;
         end else begin
            pend_vld_in = 1'b0;
         end
      end

      if (cmd.cap_loc) begin
         loc_idx_in  = pend_idx_ff;
         loc_size_in = size_rd;
      end

      if (cmd.claim_fit) begin
         free_in[pend_idx_ff] = 1'b0;
         res_addr_in = hit_data_addr[ADDR_BITS-1:0];
      end

      if (cmd.grow) begin
         if (over_limit) begin
            res_status_in = ST_NO_HEAP;
         end else if (table_full) begin
            res_status_in = ST_TABLE_FULL;
         end else begin
            free_in[cnt_idx]   = 1'b0;
            linked_in[cnt_idx] = 1'b1;
            count_in    = count_ff + CNTW'(1);
            heap_top_in = grow_sum[ADDR_BITS:0];
            res_addr_in = top_data_addr[ADDR_BITS-1:0];
         end
      end

      if (cmd.set_copy) begin
         res_copy_in = loc_size_ff;
      end

      if (cmd.set_kept) begin
         res_addr_in = item_ff.data_address;
         res_kept_in = 1'b1;
      end

      if (cmd.set_status) begin
         res_status_in = cmd.status_code;
      end

      if (cmd.rel_start) begin
         free_in[loc_idx_ff] = 1'b1;
         ptr_in = CNTW'(loc_idx_ff) + CNTW'(1);
      end

      if (cmd.rel_step) begin
         ptr_in = ptr_ff + CNTW'(1);
      end

      if (cmd.rel_merge) begin
         linked_in[ptr_idx] = 1'b0;
      end

      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_data_in.result_address = res_addr_ff;
         rsp_data_in.status         = res_status_ff;
         rsp_data_in.kept_in_place  = res_kept_ff;
         rsp_data_in.copy_bytes     = res_copy_ff;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff     <= LIMIT_RESET;
         heap_top_ff  <= '0;
         count_ff     <= '0;
         free_ff      <= '0;
         linked_ff    <= '0;
         ptr_ff       <= '0;
         pend_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         limit_ff     <= limit_in;
         heap_top_ff  <= heap_top_in;
         count_ff     <= count_in;
         free_ff      <= free_in;
         linked_ff    <= linked_in;
         ptr_ff       <= ptr_in;
         pend_vld_ff  <= pend_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff       <= item_in;
      need_ff       <= need_in;
      pend_idx_ff   <= pend_idx_in;
      loc_idx_ff    <= loc_idx_in;
      loc_size_ff   <= loc_size_in;
      res_addr_ff   <= res_addr_in;
      res_status_ff <= res_status_in;
      res_kept_ff   <= res_kept_in;
      res_copy_ff   <= res_copy_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      stat.command    = item_ff.command;
      stat.req_zero   = (item_ff.request_bytes == '0);
      stat.addr_zero  = (item_ff.data_address == '0);
      stat.scan_done  = scan_done;
      stat.scan_hit   = scan_hit;
      stat.loc_fits   = (loc_size_ff >= item_ff.request_bytes);
      stat.grow_ok    = !over_limit && !table_full;
      stat.rel_end    = (ptr_ff >= count_ff);
      stat.rel_linked = linked_ff[ptr_idx];
      stat.rel_free   = free_ff[ptr_idx];
      stat.rsp_free   = !rsp_valid_ff || !rsp_stall;
   end

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= MAX_CNT)
      else $error("block count beyond table size");

   a_top_bound: assert property (@(posedge clock) disable iff (reset)
      heap_top_ff <= {1'b0, ADDR_SPAN[ADDR_BITS-1:0]} + (ADDR_BITS + 1)'(ADDR_SPAN))
      else $error("heap top beyond address span");

   a_linked_below_count: assert property (@(posedge clock) disable iff (reset)
      (linked_ff & ({MAX_BLOCKS{1'b1}} << count_ff)) == '0)
      else $error("linked entry at or above block count");

   a_pend_in_table: assert property (@(posedge clock) disable iff (reset)
      pend_vld_ff |-> (CNTW'(pend_idx_ff) < count_ff))
      else $error("scan checked an entry outside the table");

   a_append_grows: assert property (@(posedge clock) disable iff (reset)
      grow_do |=> (count_ff == $past(count_ff) + CNTW'(1)))
      else $error("append did not bump block count");
`endif

endmodule

>>> src/ffa_ctrl.sv
// Allocator controller: sequences locate, first-fit scan, heap growth and
// release/merge, and hands the result to the output register.
// Depends on ffa_pkg.
module ffa_ctrl
   import ffa_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   output ctrl_cmd_type cmd,
   input  dp_stat_type  stat
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_LOC_SCAN,
      S_LOC_DONE,
      S_FIT_SCAN,
      S_GROW,
      S_REL_START,
      S_REL_SCAN,
      S_REL_WAIT,
      S_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      move;

   // reallocate of a live block that must move
   assign move = (stat.command == CMD_REALLOC) && !stat.addr_zero;

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = S_DECODE;
            end
         end
         S_DECODE: begin
            case (stat.command)
               CMD_ALLOC: begin
                  if (stat.req_zero) begin
                     cmd.set_status  = 1'b1;
                     cmd.status_code = ST_ZERO_SIZE;
                     state_in        = S_FINISH;
                  end else begin
                     cmd.scan_clear = 1'b1;
                     state_in       = S_FIT_SCAN;
                  end
               end
               CMD_FREE: begin
                  if (stat.addr_zero) begin
                     state_in = S_FINISH;
                  end else begin
                     cmd.scan_clear = 1'b1;
                     state_in       = S_LOC_SCAN;
                  end
               end
               CMD_REALLOC: begin
                  if (!stat.addr_zero) begin
                     cmd.scan_clear = 1'b1;
                     state_in       = S_LOC_SCAN;
                  end else if (stat.req_zero) begin
                     cmd.set_status  = 1'b1;
                     cmd.status_code = ST_ZERO_SIZE;
                     state_in        = S_FINISH;
                  end else begin
                     cmd.scan_clear = 1'b1;
                     state_in       = S_FIT_SCAN;
                  end
               end
               default: begin
                  state_in = S_FINISH;
               end
            endcase
         end
         S_LOC_SCAN: begin
            cmd.scan_run = 1'b1;
            if (stat.scan_done) begin
               if (stat.scan_hit) begin
                  cmd.cap_loc = 1'b1;
                  state_in    = S_LOC_DONE;
               end else begin
                  cmd.set_status  = 1'b1;
                  cmd.status_code = ST_UNKNOWN_ADDR;
                  state_in        = S_FINISH;
               end
            end
         end
         S_LOC_DONE: begin
            if (stat.command == CMD_FREE || stat.req_zero) begin
               state_in = S_REL_START;
            end else if (stat.loc_fits) begin
               cmd.set_kept = 1'b1;
               state_in     = S_FINISH;
            end else begin
               cmd.scan_clear = 1'b1;
               state_in       = S_FIT_SCAN;
            end
         end
         S_FIT_SCAN: begin
            cmd.scan_run = 1'b1;
            cmd.scan_fit = 1'b1;
            if (stat.scan_done) begin
               if (stat.scan_hit) begin
                  cmd.claim_fit = 1'b1;
                  cmd.set_copy  = move;
                  state_in      = move ? S_REL_START : S_FINISH;
               end else begin
                  state_in = S_GROW;
               end
            end
         end
         S_GROW: begin
            cmd.grow = 1'b1;
            if (move && stat.grow_ok) begin
               cmd.set_copy = 1'b1;
               state_in     = S_REL_START;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_REL_START: begin
            cmd.rel_start = 1'b1;
            state_in      = S_REL_SCAN;
         end
         S_REL_SCAN: begin
            // walk to the next linked block; merge only if it is free
            if (stat.rel_end) begin
               state_in = S_FINISH;
            end else if (stat.rel_linked) begin
               state_in = stat.rel_free ? S_REL_WAIT : S_FINISH;
            end else begin
               cmd.rel_step = 1'b1;
            end
         end
         S_REL_WAIT: begin
            cmd.rel_merge = 1'b1;
            state_in      = S_FINISH;
         end
         S_FINISH: begin
            if (stat.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> src/first_fit_block_allocator_core.sv
// First-fit heap block allocator, top level.
// Input channel req_* carries one command item (allocate, free, reallocate);
// result channel rsp_* returns exactly one result item per command.
// csr_wen/csr_wdata write the heap limit in bytes (write only while idle).
// An item is taken when req_valid is high and req_stall low; req_stall stays
// high while a command is being worked. The table is walked one entry per
// cycle through the offset/size RAM read port:
//   allocate        : first-fit scan, then heap growth if nothing fits
//   free            : locate, then walk to next link
//   reallocate/move : locate, fit, release
// Allocate of zero size, free of a null address and reallocate of a null address with zero size skip the table walk.
// One command is worked at a time; the result sits in an output register,
// so the next item is taken while an earlier result waits under rsp_stall.
// Synchronous reset empties the table, sets the heap top to zero and the
// limit to its default; free/linked flags are flops cleared at once, so no
// clearing pass is needed.
// Depends on ffa_pkg, ffa_ctrl, ffa_dp and ffa_ram.
module first_fit_block_allocator_core
   import ffa_pkg::*;
#(
   parameter int MAX_BLOCKS   = DEFAULT_MAX_BLOCKS,
   parameter int HEADER_BYTES = DEFAULT_HEADER_BYTES
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_item_type          req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_item_type          rsp_data,
   input  logic                  csr_wen,
   input  logic [LIMIT_BITS-1:0] csr_wdata
);

   ctrl_cmd_type cmd;
   dp_stat_type  stat;

   ffa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .cmd       (cmd),
      .stat      (stat)
   );

   ffa_dp #(
      .MAX_BLOCKS   (MAX_BLOCKS),
      .HEADER_BYTES (HEADER_BYTES)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_wen   (csr_wen),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .stat      (stat)
   );

endmodule
